/* rtl/golay24_pkg.sv */
package golay24_pkg;

   localparam int CW_W    = 24;
   localparam int DATA_W  = 12;
   localparam int SYN_W   = 11;
   localparam int BURST_W = 4;

   // Generator polynomial, bit 0 is the constant term
   localparam logic [SYN_W:0] GOLAY_POLY = 12'hC75;

   typedef logic [DATA_W-1:0][SYN_W-1:0] syn_cols_type;

   // Syndrome contributed by each data bit alone. The division is linear,
   // so the full syndrome is the xor of the columns of the set data bits.
   function automatic syn_cols_type build_syn_cols();
      syn_cols_type   cols;
      logic [SYN_W:0] rem;
      for (int b = 0; b < DATA_W; b++) begin
         rem = '0;
         for (int k = DATA_W - 1; k >= 0; k--) begin
            if (k == b) begin
               rem[0] = ~rem[0];
            end
            if (rem[0]) begin
               rem = rem ^ GOLAY_POLY;
            end
            rem = rem >> 1;
         end
         cols[b] = rem[SYN_W-1:0];
      end
      return cols;
   endfunction

   localparam syn_cols_type SYN_COLS = build_syn_cols();

   // Syndrome check handed from the syndrome unit to the correction unit
   typedef struct packed {
      logic [SYN_W-1:0] syn;
      logic             par;
   } syn_chk_type;

   // Corrected word handed to the result register
   typedef struct packed {
      logic [DATA_W-1:0]  data_bits;
      logic [BURST_W-1:0] burst_code;
      logic               failed;
   } fix_res_type;

endpackage

/* rtl/golay24_syn.sv */
module golay24_syn
   import golay24_pkg::*;
(
   input  logic [CW_W-1:0] codeword,
   output syn_chk_type     chk
);

   logic [SYN_W-1:0] data_syn;
   logic [SYN_W-1:0] check_syn;

   // Xor in the column of each set data bit
   always_comb begin
      data_syn = '0;
      for (int b = 0; b < DATA_W; b++) begin
         if (codeword[b]) begin
            data_syn = data_syn ^ SYN_COLS[b];
         end
      end
   end

   // Check bit k lands on syndrome bit 22-k
   always_comb begin
      for (int j = 0; j < SYN_W; j++) begin
         check_syn[j] = codeword[DATA_W + SYN_W - 1 - j];
      end
   end

   assign chk.syn = data_syn ^ check_syn;
   assign chk.par = ^codeword;

endmodule

/* rtl/golay24_fix.sv */
module golay24_fix
   import golay24_pkg::*;
(
   input  logic [DATA_W-1:0] data_in,
   input  syn_chk_type       chk,
   output fix_res_type       res
);

   logic               hit;
   logic [DATA_W-1:0]  mask;
   logic [BURST_W-1:0] burst;

   // Odd parity selects the upper half of the key
   always_comb begin
      hit   = 1'b1;
      mask  = '0;
      burst = '0;
      unique case ({chk.par, chk.syn})
         {1'b1, 11'd0},    {1'b1, 11'd1},    {1'b1, 11'd2},    {1'b1, 11'd4},
         {1'b1, 11'd8},    {1'b1, 11'd16},   {1'b1, 11'd32},   {1'b1, 11'd64},
         {1'b1, 11'd128},  {1'b1, 11'd256},  {1'b1, 11'd512},
         {1'b1, 11'd1024}: begin
            burst = 4'd1;
         end
         {1'b1, 11'd1594}: begin mask = 12'h001; burst = 4'd1; end
         {1'b1, 11'd797}:  begin mask = 12'h002; burst = 4'd1; end
         {1'b1, 11'd1972}: begin mask = 12'h004; burst = 4'd1; end
         {1'b1, 11'd986}:  begin mask = 12'h008; burst = 4'd1; end
         {1'b1, 11'd493}:  begin mask = 12'h010; burst = 4'd1; end
         {1'b1, 11'd1740}: begin mask = 12'h020; burst = 4'd1; end
         {1'b1, 11'd870}:  begin mask = 12'h040; burst = 4'd1; end
         {1'b1, 11'd435}:  begin mask = 12'h080; burst = 4'd1; end
         {1'b1, 11'd1763}: begin mask = 12'h100; burst = 4'd1; end
         {1'b1, 11'd1355}: begin mask = 12'h200; burst = 4'd1; end
         {1'b1, 11'd1183}: begin mask = 12'h400; burst = 4'd1; end
         {1'b1, 11'd1141}: begin mask = 12'h800; burst = 4'd1; end
         {1'b1, 11'd659}:  begin mask = 12'h007; burst = 4'd3; end
         {1'b1, 11'd1907}: begin mask = 12'h00E; burst = 4'd3; end
         {1'b1, 11'd1789}: begin mask = 12'h00B; burst = 4'd4; end
         {1'b1, 11'd1348}: begin mask = 12'h016; burst = 4'd4; end
         {1'b1, 11'd674}:  begin mask = 12'h02C; burst = 4'd4; end
         {1'b1, 11'd337}:  begin mask = 12'h058; burst = 4'd4; end
         {1'b1, 11'd1682}: begin mask = 12'h0B0; burst = 4'd4; end
         {1'b1, 11'd841}:  begin mask = 12'h160; burst = 4'd4; end
         {1'b1, 11'd1950}: begin mask = 12'h2C0; burst = 4'd4; end
         {1'b1, 11'd975}:  begin mask = 12'h580; burst = 4'd4; end
         {1'b1, 11'd2013}: begin mask = 12'hB00; burst = 4'd4; end
         {1'b1, 11'd1492}: begin mask = 12'h600; burst = 4'd4; end
         {1'b1, 11'd746}:  begin mask = 12'hC00; burst = 4'd4; end
         {1'b1, 11'd373}:  begin mask = 12'h800; burst = 4'd4; end
         {1'b1, 11'd1664}, {1'b1, 11'd832}, {1'b1, 11'd416}, {1'b1, 11'd208},
         {1'b1, 11'd104},  {1'b1, 11'd52},  {1'b1, 11'd26},  {1'b1, 11'd13},
         {1'b1, 11'd6}: begin
            burst = 4'd4;
         end
         {1'b1, 11'd1481}: begin mask = 12'h075; burst = 4'd5; end
         {1'b1, 11'd53}:   begin burst = 4'd7; end
         {1'b0, 11'd1},    {1'b0, 11'd3},    {1'b0, 11'd6},    {1'b0, 11'd12},
         {1'b0, 11'd24},   {1'b0, 11'd48},   {1'b0, 11'd96},   {1'b0, 11'd192},
         {1'b0, 11'd384},  {1'b0, 11'd768},  {1'b0, 11'd1536}: begin
            burst = 4'd2;
         end
         {1'b0, 11'd117}:  begin mask = 12'h800; burst = 4'd2; end
         {1'b0, 11'd1319}: begin mask = 12'h003; burst = 4'd2; end
         {1'b0, 11'd1193}: begin mask = 12'h006; burst = 4'd2; end
         {1'b0, 11'd1134}: begin mask = 12'h00C; burst = 4'd2; end
         {1'b0, 11'd567}:  begin mask = 12'h018; burst = 4'd2; end
         {1'b0, 11'd1825}: begin mask = 12'h030; burst = 4'd2; end
         {1'b0, 11'd1450}: begin mask = 12'h060; burst = 4'd2; end
         {1'b0, 11'd725}:  begin mask = 12'h0C0; burst = 4'd2; end
         {1'b0, 11'd1872}: begin mask = 12'h180; burst = 4'd2; end
         {1'b0, 11'd936}:  begin mask = 12'h300; burst = 4'd2; end
         {1'b0, 11'd468}:  begin mask = 12'h600; burst = 4'd2; end
         {1'b0, 11'd234}:  begin mask = 12'hC00; burst = 4'd2; end
         {1'b0, 11'd398}:  begin mask = 12'h005; burst = 4'd3; end
         {1'b0, 11'd215}, {1'b0, 11'd430}, {1'b0, 11'd860}, {1'b0, 11'd1720}: begin
            burst = 4'd8;
         end
         {1'b0, 11'd740}:  begin mask = 12'h0EB; burst = 4'd8; end
         {1'b0, 11'd370}:  begin mask = 12'h1D6; burst = 4'd8; end
         {1'b0, 11'd185}:  begin mask = 12'h3AC; burst = 4'd8; end
         {1'b0, 11'd1638}: begin mask = 12'h758; burst = 4'd8; end
         {1'b0, 11'd819}:  begin mask = 12'hEB0; burst = 4'd8; end
         {1'b0, 11'd1955}: begin mask = 12'hD60; burst = 4'd8; end
         {1'b0, 11'd1515}: begin mask = 12'hAC0; burst = 4'd8; end
         {1'b0, 11'd1231}: begin mask = 12'h580; burst = 4'd8; end
         {1'b0, 11'd1117}: begin mask = 12'hB00; burst = 4'd8; end
         {1'b0, 11'd1044}: begin mask = 12'h600; burst = 4'd8; end
         {1'b0, 11'd522}:  begin mask = 12'hC00; burst = 4'd8; end
         {1'b0, 11'd261}:  begin mask = 12'h800; burst = 4'd8; end
         {1'b0, 11'd953}:  begin mask = 12'h01D; burst = 4'd5; end
         {1'b0, 11'd2022}: begin mask = 12'h03A; burst = 4'd5; end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   assign res.data_bits  = data_in ^ mask;
   assign res.burst_code = burst;
   assign res.failed     = !hit && ((chk.syn != '0) || chk.par);

endmodule

/* rtl/golay24_burst_table_decoder.sv */
// Extended Golay (24,12) decoder with burst-pattern correction. Each input
// word carries 12 data bits (bits 0-11), 11 check bits (bits 12-22) and an
// overall parity bit (bit 23). The block forms the 11-bit syndrome and the
// overall parity, looks the pair up in a fixed table of correctable single
// and burst patterns, and returns the corrected data, the burst length code
// (0 when nothing matched), an uncorrected-error flag and an error-cleared
// flag that marks the first clean word after a failed one. An accepted word
// is held in the input register, passes the syndrome xor network and table
// decode, and is loaded into the result register when that register is
// empty or being taken; one word can be taken every cycle while rsp_stall
// does not hold the result register. Both channels use valid/stall;
// req_stall follows rsp_stall in the same cycle only when both pipeline
// registers are full.
module golay24_burst_table_decoder
   import golay24_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CW_W-1:0]    req_codeword,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DATA_W-1:0]  rsp_data_bits,
   output logic [BURST_W-1:0] rsp_burst_code,
   output logic               rsp_uncorrected_error,
   output logic               rsp_error_cleared
);

   // Input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [CW_W-1:0]   codeword_ff;

   // Result register
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [DATA_W-1:0]  data_bits_ff;
   logic [BURST_W-1:0] burst_code_ff;
   logic               uncorrected_ff;
   logic               cleared_ff;

   // Previous word had an uncorrected error
   logic              prev_failed_ff;
   logic              prev_failed_in;

   logic              out_load;
   logic              in_load;
   syn_chk_type       chk;
   fix_res_type       res;

   // Advance the result register when it is empty or being taken
   assign out_load = !out_valid_ff || !rsp_stall;
   // Take a new word when the input register is empty or moving on
   assign in_load  = !in_valid_ff || out_load;
   assign req_stall = !in_load;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   assign prev_failed_in = (out_load && in_valid_ff) ? res.failed : prev_failed_ff;

   golay24_syn u_syn (
      .codeword (codeword_ff),
      .chk      (chk)
   );

   golay24_fix u_fix (
      .data_in (codeword_ff[DATA_W-1:0]),
      .chk     (chk),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         prev_failed_ff <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         prev_failed_ff <= prev_failed_in;
      end
   end

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         codeword_ff <= req_codeword;
      end
   end

   // Capture the decoded word; hold it while the consumer stalls
   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         data_bits_ff   <= res.data_bits;
         burst_code_ff  <= res.burst_code;
         uncorrected_ff <= res.failed;
         cleared_ff     <= !res.failed && prev_failed_ff;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_data_bits         = data_bits_ff;
   assign rsp_burst_code        = burst_code_ff;
   assign rsp_uncorrected_error = uncorrected_ff;
   assign rsp_error_cleared     = cleared_ff;

endmodule
